// ----- design/tls_pkg.sv -----
// Shared types and constants for the token scanner.
package tls_pkg;

    // Token codes as delivered on token_kind
    typedef enum logic [4:0] {
        TK_SEMICOLON     = 5'd0,
        TK_IF            = 5'd1,
        TK_THEN          = 5'd2,
        TK_END           = 5'd3,
        TK_REPEAT        = 5'd4,
        TK_UNTIL         = 5'd5,
        TK_IDENTIFIER    = 5'd6,
        TK_ASSIGN        = 5'd7,
        TK_READ          = 5'd8,
        TK_WRITE         = 5'd9,
        TK_LESSTHAN      = 5'd10,
        TK_MORETHAN      = 5'd11,
        TK_EQUAL         = 5'd12,
        TK_PLUS          = 5'd13,
        TK_MINUS         = 5'd14,
        TK_MULT          = 5'd15,
        TK_DIV           = 5'd16,
        TK_OPENBRACKET   = 5'd17,
        TK_CLOSEDBRACKET = 5'd18,
        TK_NUMBER        = 5'd19,
        TK_OPENCOMMENT   = 5'd20,
        TK_CLOSEDCOMMENT = 5'd21,
        TK_BADASSIGN     = 5'd22
    } tok_kind_t;

    // Scanner mode, one-hot
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'b001,
        MODE_COLON   = 3'b010,
        MODE_COMMENT = 3'b100
    } scan_mode_t;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_item_t;

    // Output transaction payload
    typedef struct packed {
        tok_kind_t   token_kind;
        logic [26:0] number_value;
        logic [63:0] word_text;
        logic [3:0]  word_length;
        logic        word_overflow;
        logic        last;
    } token_item_t;

    // Scanner state carried from one byte to the next
    typedef struct packed {
        scan_mode_t  scan_mode;
        logic [63:0] word_buffer;
        logic [3:0]  word_count;
        logic [26:0] digit_accumulator;
        logic        leading_digits_open;
        logic        overflow_flag;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        scan_mode:           MODE_NORMAL,
        word_buffer:         64'd0,
        word_count:          4'd0,
        digit_accumulator:   27'd0,
        leading_digits_open: 1'b1,
        overflow_flag:       1'b0
    };

    localparam logic [26:0] NUM_SAT = 27'd99999999;

    // Character codes
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Keyword table: text packed first character in low byte, zero padded
    localparam int KW_NUM = 8;
    localparam logic [63:0] KW_TEXT [KW_NUM] = '{
        64'h0000_0000_0000_6669,   // if
        64'h0000_0000_6E65_6874,   // then
        64'h0000_0000_0064_6E65,   // end
        64'h0000_7461_6570_6572,   // repeat
        64'h0000_006C_6974_6E75,   // until
        64'h0000_0000_6461_6572,   // read
        64'h0000_0065_7469_7277,   // write
        64'h0000_0000_0000_007D    // closing brace
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd2, 4'd4, 4'd3, 4'd6, 4'd5, 4'd4, 4'd5, 4'd1
    };
    localparam tok_kind_t KW_KIND [KW_NUM] = '{
        TK_IF, TK_THEN, TK_END, TK_REPEAT, TK_UNTIL, TK_READ, TK_WRITE,
        TK_CLOSEDCOMMENT
    };

endpackage

// ----- design/tls_scan_step.sv -----
// Next-state and token logic for one source byte.
module tls_scan_step #(
    parameter int MAX_WORD = 8
) (
    input  tls_pkg::scan_state_t state,
    input  tls_pkg::text_item_t  item,
    output tls_pkg::scan_state_t state_next,
    output tls_pkg::token_item_t tok0,
    output tls_pkg::token_item_t tok1,
    output logic [1:0]           tok_count
);

    logic                 word_present;
    logic                 kw_hit;
    tls_pkg::tok_kind_t   kw_kind;
    logic                 first_digit;
    tls_pkg::token_item_t word_tok;
    tls_pkg::token_item_t op_tok;
    tls_pkg::token_item_t colon_tok;
    logic                 op_hit;
    tls_pkg::tok_kind_t   op_kind;
    logic                 byte_digit;
    logic [30:0]          acc_times10;
    tls_pkg::scan_state_t appended;
    logic [7:0]           b;

    assign b = item.text_byte;

    // Classify the pending word
    always_comb
    begin
        kw_hit  = 1'b0;
        kw_kind = tls_pkg::TK_IDENTIFIER;
        for (int i = tls_pkg::KW_NUM - 1; i >= 0; i--)
        begin
            if (!state.overflow_flag && state.word_count == tls_pkg::KW_LEN[i]
                && state.word_buffer == tls_pkg::KW_TEXT[i])
            begin
                kw_hit  = 1'b1;
                kw_kind = tls_pkg::KW_KIND[i];
            end
        end
        word_present = (state.word_count != 4'd0);
        first_digit  = (state.word_buffer[7:0] >= tls_pkg::CH_ZERO)
                    && (state.word_buffer[7:0] <= tls_pkg::CH_NINE);

        word_tok.token_kind    = kw_hit ? kw_kind :
                                 (first_digit ? tls_pkg::TK_NUMBER : tls_pkg::TK_IDENTIFIER);
        word_tok.number_value  = (!kw_hit && first_digit) ? state.digit_accumulator : 27'd0;
        word_tok.word_text     = state.word_buffer;
        word_tok.word_length   = state.word_count;
        word_tok.word_overflow = state.overflow_flag;
        word_tok.last          = 1'b0;
    end

    // Decode single-character operators
    always_comb
    begin
        op_hit  = 1'b1;
        op_kind = tls_pkg::TK_SEMICOLON;
        case (b)
            tls_pkg::CH_SEMI:   op_kind = tls_pkg::TK_SEMICOLON;
            tls_pkg::CH_LT:     op_kind = tls_pkg::TK_LESSTHAN;
            tls_pkg::CH_GT:     op_kind = tls_pkg::TK_MORETHAN;
            tls_pkg::CH_EQ:     op_kind = tls_pkg::TK_EQUAL;
            tls_pkg::CH_PLUS:   op_kind = tls_pkg::TK_PLUS;
            tls_pkg::CH_MINUS:  op_kind = tls_pkg::TK_MINUS;
            tls_pkg::CH_STAR:   op_kind = tls_pkg::TK_MULT;
            tls_pkg::CH_SLASH:  op_kind = tls_pkg::TK_DIV;
            tls_pkg::CH_LPAREN: op_kind = tls_pkg::TK_OPENBRACKET;
            tls_pkg::CH_RPAREN: op_kind = tls_pkg::TK_CLOSEDBRACKET;
            default:            op_hit  = 1'b0;
        endcase
        op_tok.token_kind    = op_kind;
        op_tok.number_value  = 27'd0;
        op_tok.word_text     = {56'd0, b};
        op_tok.word_length   = 4'd1;
        op_tok.word_overflow = 1'b0;
        op_tok.last          = 1'b0;

        // Token after a colon: ':' followed by this byte
        colon_tok.token_kind    = (b == tls_pkg::CH_EQ) ? tls_pkg::TK_ASSIGN
                                                        : tls_pkg::TK_BADASSIGN;
        colon_tok.number_value  = 27'd0;
        colon_tok.word_text     = {48'd0, b, tls_pkg::CH_COLON};
        colon_tok.word_length   = 4'd2;
        colon_tok.word_overflow = 1'b0;
        colon_tok.last          = 1'b0;
    end

    // Append the byte to the word and advance the digit value
    always_comb
    begin
        appended           = state;
        appended.scan_mode = tls_pkg::MODE_NORMAL;
        byte_digit  = (b >= tls_pkg::CH_ZERO) && (b <= tls_pkg::CH_NINE);
        acc_times10 = ({4'd0, state.digit_accumulator} << 3)
                    + ({4'd0, state.digit_accumulator} << 1)
                    + {23'd0, b - tls_pkg::CH_ZERO};
        if (state.leading_digits_open)
        begin
            if (byte_digit)
            begin
                if (acc_times10 > {4'd0, tls_pkg::NUM_SAT})
                    appended.digit_accumulator = tls_pkg::NUM_SAT;
                else
                    appended.digit_accumulator = acc_times10[26:0];
            end
            else
            begin
                appended.leading_digits_open = 1'b0;
            end
        end
        if (state.word_count < 4'(MAX_WORD))
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (state.word_count[2:0] == 3'(i))
                    appended.word_buffer[8*i +: 8] = b;
            end
            appended.word_count = state.word_count + 4'd1;
        end
        else
        begin
            appended.overflow_flag = 1'b1;
        end
    end

    // Select tokens and next state by mode
    always_comb
    begin
        state_next = state;
        tok0       = word_tok;
        tok1       = op_tok;
        tok_count  = 2'd0;
        if (item.end_of_text)
        begin
            state_next = tls_pkg::SCAN_RESET;
            if (state.scan_mode == tls_pkg::MODE_COLON)
            begin
                tok0             = colon_tok;
                tok0.token_kind  = tls_pkg::TK_BADASSIGN;
                tok0.word_text   = {56'd0, tls_pkg::CH_COLON};
                tok0.word_length = 4'd1;
                tok_count        = 2'd1;
            end
            else if (state.scan_mode != tls_pkg::MODE_COMMENT)
            begin
                tok_count = word_present ? 2'd1 : 2'd0;
            end
        end
        else
        begin
            case (state.scan_mode)
                tls_pkg::MODE_COLON:
                begin
                    tok0                 = colon_tok;
                    tok_count            = 2'd1;
                    state_next.scan_mode = tls_pkg::MODE_NORMAL;
                end
                tls_pkg::MODE_COMMENT:
                begin
                    if (b == tls_pkg::CH_RBRACE)
                        state_next.scan_mode = tls_pkg::MODE_NORMAL;
                end
                default:
                begin
                    state_next.scan_mode = tls_pkg::MODE_NORMAL;
                    if (op_hit)
                    begin
                        state_next = tls_pkg::SCAN_RESET;
                        if (word_present)
                        begin
                            tok_count = 2'd2;
                        end
                        else
                        begin
                            tok0      = op_tok;
                            tok_count = 2'd1;
                        end
                    end
                    else if (b == tls_pkg::CH_SPACE || b == tls_pkg::CH_COLON
                             || b == tls_pkg::CH_LBRACE)
                    begin
                        state_next = tls_pkg::SCAN_RESET;
                        if (b == tls_pkg::CH_COLON)
                            state_next.scan_mode = tls_pkg::MODE_COLON;
                        else if (b == tls_pkg::CH_LBRACE)
                            state_next.scan_mode = tls_pkg::MODE_COMMENT;
                        tok_count = word_present ? 2'd1 : 2'd0;
                    end
                    else if (b != tls_pkg::CH_NL && b != tls_pkg::CH_CR
                             && b != tls_pkg::CH_TAB)
                    begin
                        state_next = appended;
                    end
                end
            endcase
        end
        // Mark the final token of this byte
        if (tok_count == 2'd1)
            tok0.last = 1'b1;
        tok1.last = 1'b1;
    end

endmodule

// ----- design/tiny_language_token_scanner_core.sv -----
// Token scanner: takes source bytes and delivers tokens with keyword, number
// and identifier classification. One byte is accepted per clock while the
// output buffer can take its tokens. A byte is held in the input register,
// classified against the scanner state by a single combinational step, and
// its tokens (none, one or two) are loaded into a two-entry output buffer,
// from whose first entry the first token is presented. Bytes that produce at
// most one token sustain one byte per cycle while token_ready stays high; a
// byte that flushes a word and also emits an operator token fills both
// buffer entries, which is what limits the rate on operator-dense text. The
// end_of_text item flushes any pending word or lone colon and returns the
// scanner to its reset state for the next text.
module tiny_language_token_scanner_core #(
    parameter int MAX_WORD = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_ready,
    input  tls_pkg::text_item_t  text_item,
    output logic                 token_valid,
    input  logic                 token_ready,
    output tls_pkg::token_item_t token_item
);

    logic                 in_valid_reg;
    tls_pkg::text_item_t  in_item_reg;
    tls_pkg::scan_state_t state_reg;
    tls_pkg::scan_state_t state_next;
    tls_pkg::token_item_t step_tok0;
    tls_pkg::token_item_t step_tok1;
    logic [1:0]           step_count;
    tls_pkg::token_item_t res0_reg;
    tls_pkg::token_item_t res1_reg;
    logic [1:0]           res_cnt_reg;
    logic                 buf_free;
    logic                 process;
    logic                 load;
    logic                 pop;

    tls_scan_step #(
        .MAX_WORD (MAX_WORD)
    ) u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .tok0       (step_tok0),
        .tok1       (step_tok1),
        .tok_count  (step_count)
    );

    // Handshake and flow control
    assign token_valid = (res_cnt_reg != 2'd0);
    assign token_item  = res0_reg;
    assign pop         = token_valid && token_ready;
    assign buf_free    = (res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && token_ready);
    assign process     = in_valid_reg && (buf_free || step_count == 2'd0);
    assign load        = process && (step_count != 2'd0);
    assign text_ready  = !in_valid_reg || process;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= tls_pkg::SCAN_RESET;
            res_cnt_reg  <= 2'd0;
        end
        else
        begin
            if (text_ready)
                in_valid_reg <= text_valid;
            if (process)
                state_reg <= state_next;
            if (load)
                res_cnt_reg <= step_count;
            else if (pop)
                res_cnt_reg <= res_cnt_reg - 2'd1;
        end
    end

    // Payload registers: capture the byte, load or shift the token buffer
    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
            in_item_reg <= text_item;
        if (load)
        begin
            res0_reg <= step_tok0;
            res1_reg <= step_tok1;
        end
        else if (pop)
        begin
            res0_reg <= res1_reg;
        end
    end

    // Buffer never holds more than two tokens
    assert property (@(posedge clk) disable iff (!rst_n) res_cnt_reg != 2'd3)
        else $error("token buffer count out of range");

    // With two tokens buffered only the second closes its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg == 2'd2 |-> (!res0_reg.last && res1_reg.last))
        else $error("last marker misplaced in token buffer");

    // Bytes inside a comment produce no tokens
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && state_reg.scan_mode == tls_pkg::MODE_COMMENT
         && !in_item_reg.end_of_text) |-> step_count == 2'd0)
        else $error("token produced inside comment");

    // Overflow is flagged only on a full word
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.overflow_flag |-> state_reg.word_count == 4'(MAX_WORD))
        else $error("overflow flag without full word");

endmodule
